// ----- rtl/mlqs_pkg.sv -----
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared constants, codes and types of the multilevel queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlqs_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH     = 16;
  localparam int PRIORITY_LEVELS = 7;
  localparam int NUM_QUEUES      = PRIORITY_LEVELS + 1;

  // Fixed field widths
  localparam int PID_W    = 4;
  localparam int LEVEL_W  = 3;
  localparam int STATUS_W = 2;

  // Derived widths
  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int QSEL_W    = $clog2(NUM_QUEUES);
  localparam int ADDR_W    = QSEL_W + IDX_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  // Request function codes
  typedef enum logic {
    FUNC_PUT  = 1'b0,
    FUNC_TAKE = 1'b1
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Access to the entry memory
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [PID_W-1:0]  wdata;
  } ram_req_t;

  // Outcome of one request, before the memory read returns
  typedef struct packed {
    logic              valid;
    status_e           status;
    logic              take_ok;
    logic [QSEL_W-1:0] qsel;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/mlqs_ram.sv -----
// ----------------------------------------------------------------------------
// mlqs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mlqs_ram #(
  parameter int Width = 4,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/mlqs_queue_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlqs_queue_ctrl
// Head, tail and fill bookkeeping of every queue, priority selection on take,
// and the entry memory access that each request needs.
// ----------------------------------------------------------------------------
`default_nettype none

module mlqs_queue_ctrl
  import mlqs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_i,
  input  wire logic               func_i,
  input  wire logic [PID_W-1:0]   proc_id_i,
  input  wire logic [LEVEL_W-1:0] level_i,
  output      ram_req_t           ram_req_o,
  output      rsp_t               rsp_o
);

  logic [IDX_W-1:0] head_q  [NUM_QUEUES];
  logic [IDX_W-1:0] head_d  [NUM_QUEUES];
  logic [IDX_W-1:0] tail_q  [NUM_QUEUES];
  logic [IDX_W-1:0] tail_d  [NUM_QUEUES];
  logic [CNT_W-1:0] count_q [NUM_QUEUES];
  logic [CNT_W-1:0] count_d [NUM_QUEUES];

  logic              found;
  logic [QSEL_W-1:0] sel;
  logic              lvl_ok;
  logic [QSEL_W-1:0] lq;
  logic              full;

  // Pick the lowest non-empty priority level, else the round-robin queue
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = NUM_QUEUES - 1; i >= 1; i--) begin
      if (count_q[i] != '0) begin
        found = 1'b1;
        sel   = QSEL_W'(i);
      end
    end
    if (!found && count_q[0] != '0) begin
      found = 1'b1;
    end
  end

  // Check the put target
  assign lvl_ok = 32'(level_i) < NUM_QUEUES;
  assign lq     = QSEL_W'(level_i);
  assign full   = !lvl_ok || (count_q[lq] >= CNT_W'(QUEUE_DEPTH));

  // Advance pointers and issue the memory access
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    ram_req_o = '0;
    rsp_o     = '0;
    rsp_o.status = ST_OK;
    if (req_i) begin
      rsp_o.valid = 1'b1;
      if (func_i == FUNC_PUT) begin
        if (full) begin
          rsp_o.status = ST_FULL;
        end else begin
          ram_req_o.we    = 1'b1;
          ram_req_o.addr  = {lq, tail_q[lq]};
          ram_req_o.wdata = proc_id_i;
          tail_d[lq]  = (32'(tail_q[lq]) == QUEUE_DEPTH - 1) ? '0 : tail_q[lq] + 1'b1;
          count_d[lq] = count_q[lq] + 1'b1;
        end
      end else begin
        if (!found) begin
          rsp_o.status = ST_EMPTY;
        end else begin
          rsp_o.take_ok = 1'b1;
          rsp_o.qsel    = sel;
          ram_req_o.re   = 1'b1;
          ram_req_o.addr = {sel, head_q[sel]};
          head_d[sel]  = (32'(head_q[sel]) == QUEUE_DEPTH - 1) ? '0 : head_q[sel] + 1'b1;
          count_d[sel] = count_q[sel] - 1'b1;
        end
      end
    end
  end

  // Hold queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multilevel_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler
// Strict-priority multilevel FIFO scheduler: put appends an identifier to a
// queue, take removes the head of the first non-empty priority queue, falling
// back to the round-robin queue.
//
//   Channel   Handshake            Payload
//   request   start / busy         func_i, proc_id_i, level_i
//   result    done_o (one cycle)   status_o, out_proc_id_o, out_level_o
//
// One request is taken every cycle; busy stays low.
// Each result appears in the cycle after its request is taken, with the
// identifier from the registered read of the entry memory.
// Reset empties every queue at once; entry memory contents are not cleared.
// The receiver cannot stall: done_o lasts exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_queue_scheduler
  import mlqs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic                func_i,
  input  wire logic [PID_W-1:0]    proc_id_i,
  input  wire logic [LEVEL_W-1:0]  level_i,
  output      logic                done_o,
  output      logic [STATUS_W-1:0] status_o,
  output      logic [PID_W-1:0]    out_proc_id_o,
  output      logic [LEVEL_W-1:0]  out_level_o
);

  ram_req_t          ram_req;
  rsp_t              rsp;
  logic [PID_W-1:0]  rdata;
  logic              done_q;
  status_e           status_q;
  logic              take_ok_q;
  logic [QSEL_W-1:0] qsel_q;

  assign busy = 1'b0;

  mlqs_queue_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (start && !busy),
    .func_i    (func_i),
    .proc_id_i (proc_id_i),
    .level_i   (level_i),
    .ram_req_o (ram_req),
    .rsp_o     (rsp)
  );

  mlqs_ram #(
    .Width (PID_W),
    .Depth (RAM_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (rdata)
  );

  // Register the request outcome alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp.valid) begin
      status_q  <= rsp.status;
      take_ok_q <= rsp.take_ok;
      qsel_q    <= rsp.qsel;
    end
  end

  // Drive the result, zero fields unless a take succeeded
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_proc_id_o = take_ok_q ? rdata : '0;
  assign out_level_o   = take_ok_q ? LEVEL_W'(qsel_q) : '0;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multilevel queue scheduler. A queue of pending
// put and take requests feeds a clocked driver with random gaps; a clocked
// monitor mirrors the eight bounded FIFOs, predicts each result and compares
// it field by field with the one-cycle result strobe.
// ----------------------------------------------------------------------------
module tb;
  import mlqs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    func_e               func;
    logic [PID_W-1:0]    pid;
    logic [LEVEL_W-1:0]  level;
    bit                  hold;   // wait for every result before issuing
  } sched_req_t;

  typedef struct {
    status_e             status;
    logic [PID_W-1:0]    pid;
    logic [LEVEL_W-1:0]  level;
  } sched_res_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                start     = 1'b0;
  logic                func_i    = 1'b0;
  logic [PID_W-1:0]    proc_id_i = '0;
  logic [LEVEL_W-1:0]  level_i   = '0;
  logic                busy;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [PID_W-1:0]    out_proc_id_o;
  logic [LEVEL_W-1:0]  out_level_o;

  sched_req_t pending_reqs[$];
  sched_res_t awaited_results[$];

  // Mirror of the scheduler queues
  logic [PID_W-1:0] mirror_ids [NUM_QUEUES][QUEUE_DEPTH];
  int               mirror_head[NUM_QUEUES];
  int               mirror_tail[NUM_QUEUES];
  int               mirror_fill[NUM_QUEUES];

  int fail_count  = 0;
  int in_flight   = 0;
  int issued      = 0;
  int quiet_count = 0;

  multilevel_queue_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .proc_id_i     (proc_id_i),
    .level_i       (level_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_proc_id_o (out_proc_id_o),
    .out_level_o   (out_level_o)
  );

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one request to the mirror and return the result it must produce
  function automatic sched_res_t schedule_outcome(input func_e f,
                                                  input logic [PID_W-1:0] pid,
                                                  input logic [LEVEL_W-1:0] lvl);
    sched_res_t res;
    int         q;
    res.status = ST_OK;
    res.pid    = '0;
    res.level  = '0;
    q          = -1;
    if (f == FUNC_PUT) begin
      if (int'(lvl) >= NUM_QUEUES || mirror_fill[lvl] >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        mirror_ids[lvl][mirror_tail[lvl]] = pid;
        mirror_tail[lvl] = (mirror_tail[lvl] + 1) % QUEUE_DEPTH;
        mirror_fill[lvl]++;
      end
    end else begin
      // Strict priority 1 upwards, round-robin queue last
      for (int i = 1; i < NUM_QUEUES; i++) begin
        if (q < 0 && mirror_fill[i] != 0) q = i;
      end
      if (q < 0 && mirror_fill[0] != 0) q = 0;
      if (q < 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.pid   = mirror_ids[q][mirror_head[q]];
        res.level = LEVEL_W'(q);
        mirror_head[q] = (mirror_head[q] + 1) % QUEUE_DEPTH;
        mirror_fill[q]--;
      end
    end
    return res;
  endfunction

  // Request driver: hold until accepted, then issue the next or idle
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic       accepted;
    int         flight_next;
    int         idle_pct;
    bit         give;
    sched_req_t nxt;
    if (!rst_ni) begin
      start     <= 1'b0;
      func_i    <= 1'b0;
      proc_id_i <= '0;
      level_i   <= '0;
      in_flight <= 0;
    end else begin
      accepted    = start && !busy;
      flight_next = in_flight + int'(accepted) - int'(done_o === 1'b1);
      // Sender idling: light, heavy, then none
      if (issued < RANDOM_ITEMS / 3)          idle_pct = 11;
      else if (issued < 2 * RANDOM_ITEMS / 3) idle_pct = 81;
      else                                    idle_pct = 0;
      if (!start || accepted) begin
        give = 1'b0;
        if (pending_reqs.size() != 0) begin
          if (pending_reqs[0].hold && flight_next != 0) give = 1'b0;
          else give = ($urandom_range(99) >= idle_pct);
        end
        if (give) begin
          nxt = pending_reqs.pop_front();
          start     <= 1'b1;
          func_i    <= nxt.func;
          proc_id_i <= nxt.pid;
          level_i   <= nxt.level;
          issued++;
        end else begin
          start <= 1'b0;
        end
      end
      in_flight <= flight_next;
    end
  end

  // Result monitor: check the strobe, then record any newly accepted request
  always @(posedge clk_i) begin : observe
    sched_res_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result: status %0d id %0d level %0d",
                     status_o, out_proc_id_o, out_level_o);
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status || out_proc_id_o !== want.pid ||
              out_level_o !== want.level) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("mismatch: status %0d/%0d id %0d/%0d level %0d/%0d (want/got)",
                       want.status, status_o, want.pid, out_proc_id_o,
                       want.level, out_level_o);
          end
        end
      end
      if (start && !busy)
        awaited_results.push_back(schedule_outcome(func_e'(func_i), proc_id_i, level_i));
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o === 1'b1) quiet_count = 0;
      else quiet_count++;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic queue_put(input logic [LEVEL_W-1:0] lvl, input logic [PID_W-1:0] pid,
                           input bit hold);
    sched_req_t r;
    r.func  = FUNC_PUT;
    r.pid   = pid;
    r.level = lvl;
    r.hold  = hold;
    pending_reqs.push_back(r);
  endtask

  // Take carries random filler in the ignored fields
  task automatic queue_take(input bit hold);
    sched_req_t r;
    r.func  = FUNC_TAKE;
    r.pid   = PID_W'($urandom);
    r.level = LEVEL_W'($urandom);
    r.hold  = hold;
    pending_reqs.push_back(r);
  endtask

  // Stimulus and end of run
  initial begin
    int planned;
    int kind;
    int n;
    int lvl;
    bit hold;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      mirror_head[q] = 0;
      mirror_tail[q] = 0;
      mirror_fill[q] = 0;
      for (int e = 0; e < QUEUE_DEPTH; e++) mirror_ids[q][e] = '0;
    end

    // Directed: take on empty, a put to every queue (two to level 1), then drain past empty
    queue_take(1'b0);
    queue_put(3'd0, 4'hF, 1'b0);
    queue_put(3'd7, 4'h0, 1'b0);
    queue_put(3'd1, 4'hA, 1'b0);
    queue_put(3'd4, 4'h5, 1'b0);
    queue_put(3'd1, 4'h3, 1'b0);
    queue_put(3'd2, 4'hC, 1'b0);
    queue_put(3'd6, 4'h9, 1'b0);
    queue_put(3'd3, 4'h6, 1'b0);
    queue_put(3'd5, 4'h1, 1'b0);
    for (int i = 0; i < 10; i++) queue_take(1'b0);

    // Random episodes: fill bursts, mixed traffic and drains
    planned = 0;
    while (planned < RANDOM_ITEMS) begin
      hold = (planned == 0) || ($urandom_range(7) == 0);
      kind = $urandom_range(9);
      if (kind < 4) begin
        // Fill one queue, often past full
        lvl = $urandom_range(NUM_QUEUES - 1);
        n   = $urandom_range(12, 20);
        for (int i = 0; i < n; i++) begin
          queue_put(LEVEL_W'(lvl), PID_W'($urandom), hold);
          hold = 1'b0;
        end
        planned += n;
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) queue_take(1'b0);
        planned += n;
      end else if (kind < 8) begin
        n = $urandom_range(10, 40);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(1) == 0)
            queue_put(LEVEL_W'($urandom), PID_W'($urandom), hold);
          else
            queue_take(hold);
          hold = 1'b0;
        end
        planned += n;
      end else begin
        n = $urandom_range(8, 40);
        for (int i = 0; i < n; i++) begin
          queue_take(hold);
          hold = 1'b0;
        end
        planned += n;
      end
    end

    // Reset once
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain, then let the pipeline settle
    while (pending_reqs.size() != 0 || start || awaited_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      fail_count += awaited_results.size();
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
